// File: rtl/kcht_pkg.sv
// Package for the keyed chained hash table unit.
// Holds the transaction structs and operation codes; depends on nothing.
`default_nettype none

package kcht_pkg;

   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_DELETE  = 3'd1;
   localparam logic [2:0] OP_GET     = 3'd2;
   localparam logic [2:0] OP_PID     = 3'd3;
   localparam logic [2:0] OP_IS_ACT  = 3'd4;
   localparam logic [2:0] OP_SET_ACT = 3'd5;

   typedef struct packed {
      logic [2:0]  operation;
      logic [30:0] proc_num;
      logic [30:0] thread_num;
      logic [31:0] payload_handle;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] handle_out;
      logic        active_out;
      logic        status;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/keyed_chained_hash_table_unit.sv
// Keyed chained hash table unit: bucket heads and node pool in synchronous memories.
// Depends on kcht_pkg for the transaction structs and operation codes.
//
//   Channel | Direction | Handshake               | Payload
//   req     | in        | req_valid / req_stall   | kcht_pkg::req_type
//   rsp     | out       | rsp_valid / rsp_stall   | kcht_pkg::rsp_type
//
// Sequence: one transaction is worked on at a time. After the accept come the bucket
// remainder (a reciprocal multiplication, then a correcting subtract), the bucket head
// read, then the chain walk, in which every node visited is a read of the single node
// memory read port. A delete adds a write, and an add whose free node was recycled
// adds a read.
// Reset: synchronous and active high; afterwards a clearing pass over every bucket
// empties the bucket head memory, during which req_stall is high.
// Stalls: the result sits in an output register, so a new request is taken while a
// stalled result waits; the unit only holds back a finished result if the register
// is still full.
`default_nettype none

module keyed_chained_hash_table_unit #(
   parameter int BUCKETS      = 64,
   parameter int POOL_ENTRIES = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire kcht_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output kcht_pkg::rsp_type      rsp_data
);

   // Link width holds POOL_ENTRIES itself, which is the empty link.
   localparam int LW = $clog2(POOL_ENTRIES + 1);
   localparam int NW = $clog2(POOL_ENTRIES);
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int LB = $clog2(BUCKETS);
   localparam int RW = $clog2(BUCKETS) + 1;
   localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);
   // Reciprocal of BUCKETS rounded down; the quotient it gives is exact or one short.
   localparam logic [31:0] RECIP = 32'((64'd1 << (31 + LB)) / 64'(BUCKETS));

   typedef struct packed {
      logic [30:0]   proc_num;
      logic [30:0]   thread_num;
      logic [31:0]   handle;
      logic          active;
      logic [LW-1:0] link;
   } node_type;

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_MOD   = 10'b0000000100,
      S_HEAD  = 10'b0000001000,
      S_HWAIT = 10'b0000010000,
      S_FWAIT = 10'b0000100000,
      S_NODE  = 10'b0001000000,
      S_WRN   = 10'b0010000000,
      S_DONE  = 10'b0100000000,
      S_SPARE = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]    op_ff, op_in;
   logic [30:0]   pn_ff, pn_in;
   logic [30:0]   tn_ff, tn_in;
   logic [31:0]   hd_ff, hd_in;
   logic [31:0]   sh_ff, sh_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic [BW-1:0] clr_ff, clr_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic [LW-1:0] prev_ff, prev_in;
   node_type      prev_ent_ff, prev_ent_in;
   logic [LW-1:0] free_ff, free_in;
   logic [LW-1:0] fill_ff, fill_in;
   kcht_pkg::rsp_type res_ff, res_in;
   kcht_pkg::rsp_type rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Memories and their ports.
   logic [LW-1:0] bkt_mem [BUCKETS];
   logic [LW-1:0] bkt_q_ff;
   logic          bkt_we, bkt_re;
   logic [BW-1:0] bkt_wa;
   logic [LW-1:0] bkt_wd;

   node_type      node_mem [POOL_ENTRIES];
   node_type      node_q_ff;
   logic          nd_we, nd_re;
   logic [NW-1:0] nd_wa, nd_ra;
   node_type      nd_wd;

   logic          load_rsp;
   logic          match;
   logic [62:0]   prod;
   logic [31:0]   qb;
   logic [31:0]   diff;

   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bkt_mem[bkt_wa] <= bkt_wd;
      end
      if (bkt_re) begin
         bkt_q_ff <= bkt_mem[rem_ff[BW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (nd_we) begin
         node_mem[nd_wa] <= nd_wd;
      end
      if (nd_re) begin
         node_q_ff <= node_mem[nd_ra];
      end
   end

   assign match = (node_q_ff.proc_num == pn_ff) &&
                  ((op_ff == kcht_pkg::OP_PID) || (node_q_ff.thread_num == tn_ff));

   assign req_stall = (state_ff != S_IDLE);
   assign load_rsp  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      pn_in       = pn_ff;
      tn_in       = tn_ff;
      hd_in       = hd_ff;
      sh_in       = sh_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      clr_in      = clr_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      prev_ent_in = prev_ent_ff;
      free_in     = free_ff;
      fill_in     = fill_ff;
      res_in      = res_ff;
      bkt_we      = 1'b0;
      bkt_re      = 1'b0;
      bkt_wa      = rem_ff[BW-1:0];
      bkt_wd      = NIL;
      nd_we       = 1'b0;
      nd_re       = 1'b0;
      nd_wa       = cur_ff[NW-1:0];
      nd_ra       = cur_ff[NW-1:0];
      nd_wd       = node_q_ff;
      prod        = '0;
      qb          = '0;
      diff        = '0;

      case (state_ff)
         S_CLEAR: begin
            bkt_we = 1'b1;
            bkt_wa = clr_ff;
            clr_in = clr_ff + BW'(1);
            if (clr_ff == BW'(BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in  = req_data.operation;
               pn_in  = req_data.proc_num;
               tn_in  = req_data.thread_num;
               hd_in  = req_data.payload_handle;
               sh_in  = {1'b0, req_data.proc_num};
               rem_in = '0;
               cnt_in = '0;
               res_in = '0;
               if (req_data.operation > kcht_pkg::OP_SET_ACT) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            // Remainder by BUCKETS: the first step forms a quotient that is exact or
            // one short, the second subtracts it and corrects by one more subtract.
            if (cnt_ff == 2'd0) begin
               prod  = {32'd0, pn_ff} * {31'd0, RECIP};
               sh_in = 32'(prod >> (31 + LB));
            end else begin
               qb   = sh_ff * 32'(BUCKETS);
               diff = {1'b0, pn_ff} - qb;
               if (diff >= 32'(BUCKETS)) begin
                  diff = diff - 32'(BUCKETS);
               end
               rem_in   = diff[RW-1:0];
               state_in = S_HEAD;
            end
            cnt_in = cnt_ff + 2'd1;
         end
         S_HEAD: begin
            bkt_re   = 1'b1;
            state_in = S_HWAIT;
         end
         S_HWAIT: begin
            if (op_ff == kcht_pkg::OP_ADD) begin
               if (free_ff == NIL) begin
                  res_in.status = 1'b1;
                  state_in      = S_DONE;
               end else if (free_ff == fill_ff) begin
                  // Never used node: its link is simply the next index.
                  nd_we    = 1'b1;
                  nd_wa    = free_ff[NW-1:0];
                  nd_wd    = '{pn_ff, tn_ff, hd_ff, 1'b0, bkt_q_ff};
                  bkt_we   = 1'b1;
                  bkt_wd   = free_ff;
                  free_in  = fill_ff + LW'(1);
                  fill_in  = fill_ff + LW'(1);
                  state_in = S_DONE;
               end else begin
                  nd_re    = 1'b1;
                  nd_ra    = free_ff[NW-1:0];
                  state_in = S_FWAIT;
               end
            end else begin
               prev_in = NIL;
               cur_in  = bkt_q_ff;
               if (bkt_q_ff == NIL) begin
                  state_in = S_DONE;
               end else begin
                  nd_re    = 1'b1;
                  nd_ra    = bkt_q_ff[NW-1:0];
                  state_in = S_NODE;
               end
            end
         end
         S_FWAIT: begin
            nd_we    = 1'b1;
            nd_wa    = free_ff[NW-1:0];
            nd_wd    = '{pn_ff, tn_ff, hd_ff, 1'b0, bkt_q_ff};
            bkt_we   = 1'b1;
            bkt_wd   = free_ff;
            free_in  = node_q_ff.link;
            state_in = S_DONE;
         end
         S_NODE: begin
            if (match) begin
               res_in.found = 1'b1;
               state_in     = S_DONE;
               case (op_ff)
                  kcht_pkg::OP_GET:    res_in.handle_out = node_q_ff.handle;
                  kcht_pkg::OP_IS_ACT: res_in.active_out = node_q_ff.active;
                  kcht_pkg::OP_SET_ACT: begin
                     nd_we        = 1'b1;
                     nd_wd        = node_q_ff;
                     nd_wd.active = 1'b1;
                  end
                  kcht_pkg::OP_DELETE: begin
                     if (prev_ff == NIL) begin
                        bkt_we = 1'b1;
                        bkt_wd = node_q_ff.link;
                     end else begin
                        nd_we      = 1'b1;
                        nd_wa      = prev_ff[NW-1:0];
                        nd_wd      = prev_ent_ff;
                        nd_wd.link = node_q_ff.link;
                     end
                     state_in = S_WRN;
                  end
                  default: ;
               endcase
            end else begin
               prev_in     = cur_ff;
               prev_ent_in = node_q_ff;
               cur_in      = node_q_ff.link;
               if (node_q_ff.link == NIL) begin
                  state_in = S_DONE;
               end else begin
                  nd_re = 1'b1;
                  nd_ra = node_q_ff.link[NW-1:0];
               end
            end
         end
         S_WRN: begin
            // Return the unlinked node to the front of the free list.
            nd_we      = 1'b1;
            nd_wd      = node_q_ff;
            nd_wd.link = free_ff;
            free_in    = cur_ff;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pn_ff       <= pn_in;
      tn_ff       <= tn_in;
      hd_ff       <= hd_in;
      sh_ff       <= sh_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      prev_ent_ff <= prev_ent_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_full_means_filled: assert property (@(posedge clock) disable iff (reset)
      (free_ff == NIL) |-> (fill_ff == NIL))
      else $error("free list empty while untouched nodes remain");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= NIL)
      else $error("fill count beyond pool size");

   a_status_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.status && rsp_data.found))
      else $error("dropped add reported a match");

   a_handle_needs_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.handle_out != 32'd0)) |-> rsp_data.found)
      else $error("handle returned without a match");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted transaction was not started");
`endif

endmodule

`default_nettype wire

// File: tb/kcht_checker.sv
// Checker for the keyed chained hash table unit: watches both channels, predicts results.
// Depends on kcht_pkg for the transaction structs and operation codes.
`timescale 1ns / 100ps

module kcht_checker #(
   parameter int BUCKETS      = 64,
   parameter int POOL_ENTRIES = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire kcht_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire kcht_pkg::rsp_type rsp_data,
   output int                     fail_count,
   output int                     pending_count
);

   localparam int NIL = POOL_ENTRIES;

   int          head_of_bucket [BUCKETS];
   logic [30:0] entry_proc [POOL_ENTRIES];
   logic [30:0] entry_thread [POOL_ENTRIES];
   logic [31:0] entry_handle [POOL_ENTRIES];
   logic        entry_active [POOL_ENTRIES];
   int          next_entry [POOL_ENTRIES];
   int          free_first;
   kcht_pkg::rsp_type awaited_rsps [$];

   // Walks one chain; returns the first match and its predecessor.
   function automatic int lookup_entry(int b, logic [30:0] pn, logic [30:0] tn,
                                       bit by_thread, output int pred);
      int p;
      int pv;
      int steps;
      p = head_of_bucket[b];
      pv = NIL;
      steps = 0;
      pred = NIL;
      while (p < NIL && steps < POOL_ENTRIES) begin
         if (entry_proc[p] == pn && (!by_thread || entry_thread[p] == tn)) begin
            pred = pv;
            return p;
         end
         pv = p;
         p = next_entry[p];
         steps++;
      end
      return NIL;
   endfunction

   function automatic kcht_pkg::rsp_type apply_request(kcht_pkg::req_type r);
      kcht_pkg::rsp_type res;
      int b;
      int n;
      int pv;
      res = '0;
      b = r.proc_num % BUCKETS;
      case (r.operation)
         kcht_pkg::OP_ADD: begin
            if (free_first >= NIL) begin
               res.status = 1'b1;
            end else begin
               n = free_first;
               free_first = next_entry[n];
               entry_proc[n] = r.proc_num;
               entry_thread[n] = r.thread_num;
               entry_handle[n] = r.payload_handle;
               entry_active[n] = 1'b0;
               next_entry[n] = head_of_bucket[b];
               head_of_bucket[b] = n;
            end
         end
         kcht_pkg::OP_DELETE: begin
            n = lookup_entry(b, r.proc_num, r.thread_num, 1'b1, pv);
            if (n < NIL) begin
               res.found = 1'b1;
               if (pv < NIL) next_entry[pv] = next_entry[n];
               else head_of_bucket[b] = next_entry[n];
               next_entry[n] = free_first;
               free_first = n;
            end
         end
         kcht_pkg::OP_GET: begin
            n = lookup_entry(b, r.proc_num, r.thread_num, 1'b1, pv);
            if (n < NIL) begin
               res.found = 1'b1;
               res.handle_out = entry_handle[n];
            end
         end
         kcht_pkg::OP_PID: begin
            n = lookup_entry(b, r.proc_num, r.thread_num, 1'b0, pv);
            if (n < NIL) res.found = 1'b1;
         end
         kcht_pkg::OP_IS_ACT: begin
            n = lookup_entry(b, r.proc_num, r.thread_num, 1'b1, pv);
            if (n < NIL) begin
               res.found = 1'b1;
               res.active_out = entry_active[n];
            end
         end
         kcht_pkg::OP_SET_ACT: begin
            n = lookup_entry(b, r.proc_num, r.thread_num, 1'b1, pv);
            if (n < NIL) begin
               res.found = 1'b1;
               entry_active[n] = 1'b1;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   initial begin
      for (int i = 0; i < BUCKETS; i++) head_of_bucket[i] = NIL;
      for (int i = 0; i < POOL_ENTRIES; i++) begin
         next_entry[i] = i + 1;
         entry_proc[i] = '0;
         entry_thread[i] = '0;
         entry_handle[i] = '0;
         entry_active[i] = 1'b0;
      end
      free_first = 0;
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      kcht_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) awaited_rsps.push_back(apply_request(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result %h", $realtime, rsp_data);
            end else begin
               want = awaited_rsps.pop_front();
               if (want.found !== rsp_data.found || want.handle_out !== rsp_data.handle_out
                   || want.active_out !== rsp_data.active_out
                   || want.status !== rsp_data.status) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch found %b/%b handle %h/%h active %b/%b status %b/%b",
                              $realtime, want.found, rsp_data.found, want.handle_out,
                              rsp_data.handle_out, want.active_out, rsp_data.active_out,
                              want.status, rsp_data.status);
               end
            end
         end
         pending_count = awaited_rsps.size();
      end
   end

endmodule

// File: tb/tb_keyed_chained_hash_table_unit.sv
// Testbench top for the keyed chained hash table unit: stimulus, idling and verdict.
// Depends on kcht_pkg, the unit itself and the kcht_checker module.
`timescale 1ns / 100ps

module tb_keyed_chained_hash_table_unit;

   localparam int BUCKETS      = 64;
   localparam int POOL_ENTRIES = 1024;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   kcht_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   kcht_pkg::rsp_type rsp_data;
   int      fail_count;
   int      pending_count;

   // Idling percentages for each side; the stimulus process moves through the phases.
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   // A long hold-off of the receiver, counted down in its own process.
   int      hold_cycles = 0;

   // Keys already added, so that most lookups and deletes hit something.
   logic [30:0] known_proc [$];
   logic [30:0] known_thread [$];

   always #2 clock = ~clock;

   keyed_chained_hash_table_unit #(.BUCKETS(BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   kcht_checker #(.BUCKETS(BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)) checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // The receiver stalls at random, or solidly while a hold-off is counting down.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offers one transaction and waits until the unit takes it. Valid is lowered at
   // the accepting edge and held low until the following edge, while the unit is busy anyway,
   // so it is never lowered and raised in the same step.
   task automatic send_request(logic [2:0] op, logic [30:0] pn, logic [30:0] tn,
                               logic [31:0] hd);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_data <= '{operation: op, proc_num: pn, thread_num: tn, payload_handle: hd};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_valid <= 1'b0;
      if (op == kcht_pkg::OP_ADD) begin
         known_proc.push_back(pn);
         known_thread.push_back(tn);
      end
      @(posedge clock);
   endtask

   // Mostly keys that exist, sometimes a neighbour sharing the process number,
   // and now and then a fresh random key. Process numbers are often kept small,
   // so that chains grow long and several keys share a bucket.
   task automatic send_random;
      logic [2:0]  op;
      logic [30:0] pn;
      logic [30:0] tn;
      int          pick;
      int          k;
      pick = $urandom_range(99);
      if (pick < 35) op = kcht_pkg::OP_ADD;
      else if (pick < 97) op = 3'($urandom_range(5, 1));
      else op = 3'($urandom_range(7, 6));
      if (known_proc.size() > 0 && $urandom_range(99) < 75) begin
         k = $urandom_range(known_proc.size() - 1);
         pn = known_proc[k];
         tn = ($urandom_range(9) == 0) ? 31'($urandom_range(3)) : known_thread[k];
      end else if ($urandom_range(1) == 0) begin
         pn = 31'($urandom_range(300));
         tn = 31'($urandom_range(7));
      end else begin
         pn = 31'($urandom);
         tn = 31'($urandom);
      end
      send_request(op, pn, tn, $urandom);
   endtask

   task automatic wait_drained;
      do @(posedge clock); while (pending_count != 0 || req_valid);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: the extremes of each field, every operation, a miss of
      // each kind, a duplicate key that resolves to the newest entry, and the
      // unknown operation codes.
      send_request(kcht_pkg::OP_GET, 31'h0, 31'h0, 32'hFFFF_FFFF);
      send_request(kcht_pkg::OP_DELETE, 31'h0, 31'h0, 32'h0);
      send_request(kcht_pkg::OP_IS_ACT, 31'h0, 31'h0, 32'h0);
      send_request(kcht_pkg::OP_SET_ACT, 31'h0, 31'h0, 32'h0);
      send_request(kcht_pkg::OP_PID, 31'h0, 31'h0, 32'h0);
      send_request(kcht_pkg::OP_ADD, 31'h0, 31'h0, 32'h0);
      send_request(kcht_pkg::OP_ADD, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(kcht_pkg::OP_ADD, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h5A5A_A5A5);
      send_request(kcht_pkg::OP_GET, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h0);
      send_request(kcht_pkg::OP_IS_ACT, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h0);
      send_request(kcht_pkg::OP_SET_ACT, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h0);
      send_request(kcht_pkg::OP_IS_ACT, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h0);
      send_request(kcht_pkg::OP_PID, 31'h7FFF_FFFF, 31'h0, 32'h0);
      send_request(kcht_pkg::OP_DELETE, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h0);
      send_request(kcht_pkg::OP_GET, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h0);
      send_request(kcht_pkg::OP_ADD, 31'd64, 31'd1, 32'h1234_5678);
      send_request(kcht_pkg::OP_GET, 31'd64, 31'd1, 32'h0);
      send_request(kcht_pkg::OP_GET, 31'h0, 31'h0, 32'h0);
      send_request(kcht_pkg::OP_DELETE, 31'h0, 31'h0, 32'h0);
      send_request(3'd6, 31'd64, 31'd1, 32'hFFFF_FFFF);
      send_request(3'd7, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);

      // The sender pauses here until every expected result has arrived.
      wait_drained();

      // Fill the pool past its end so that adds are dropped, then drain some of it.
      for (int i = 0; i < POOL_ENTRIES + 8 - 4; i++)
         send_request(kcht_pkg::OP_ADD, 31'($urandom_range(200)), 31'($urandom_range(3)),
                      $urandom);
      for (int i = 0; i < 60; i++) send_random();
      for (int i = 0; i < 40; i++)
         send_request(kcht_pkg::OP_DELETE, known_proc[i], known_thread[i], 32'h0);

      // Random phases with the idling swapped between the two sides.
      send_idle_pct = 16;
      recv_idle_pct = 73;
      for (int i = 0; i < 150; i++) send_random();
      // A long receiver hold-off while the sender keeps offering transactions.
      hold_cycles = 300;
      for (int i = 0; i < 50; i++) send_random();
      send_idle_pct = 73;
      recv_idle_pct = 16;
      for (int i = 0; i < 150; i++) send_random();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 100; i++) send_random();

      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("** keyed_chained_hash_table_unit: PASSED **");
      end else begin
         $display("** keyed_chained_hash_table_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("** keyed_chained_hash_table_unit: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
rtl/kcht_pkg.sv
rtl/keyed_chained_hash_table_unit.sv
tb/kcht_checker.sv
tb/tb_keyed_chained_hash_table_unit.sv
